// ----- sv/threshold_marking_fifo_assert.svh -----
// Assertion macros shared by the queue RTL.
`ifndef THRESHOLD_MARKING_FIFO_ASSERT_SVH
`define THRESHOLD_MARKING_FIFO_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define TMF_ASSERT_IMPLY(lbl, c, r, ante, cons, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset-qualified.
`define TMF_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tmf_pkg.sv -----
package tmf_pkg;

	localparam int TMF_QUEUE_DEPTH = 1024;
	localparam int TMF_DESC_BITS   = 32;

	localparam int REG_W      = 11;
	localparam int CNT_W      = 11;
	localparam int DESC_PORT_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [REG_W-1:0] LIMIT_RESET  = 11'd1000;
	localparam logic [REG_W-1:0] THRESH_RESET = 11'd40;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 2'd1;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic {
		ST_ACCEPT,
		ST_FETCH
	} tmf_state_t;

endpackage

// ----- sv/threshold_marking_fifo.sv -----
// Packet-descriptor queue with threshold congestion marking.
// Request channel (req_valid / req_stall): opcode enqueue or dequeue plus a
// descriptor. Each request beat yields exactly one response beat on the
// response channel (rsp_valid / rsp_stall) carrying accept/drop/mark flags,
// the dequeued entry, the occupancy after the step and the new head (peek).
// Configuration (cfg_valid / cfg_ready, always ready): index 0 sets the
// queue limit, index 1 the mark threshold; write only while idle.
// Timing: enqueues, drops, empty dequeues and dequeues that empty the queue
// deliver in the cycle after acceptance and sustain one beat per cycle while
// the receiver does not stall. A dequeue that leaves one or more entries must
// fetch the new head from the entry RAM (one read port, registered read), so
// it waits for the fetch and holds the request side stalled during the fetch.
// The response register parts the two sides: a new request is taken while
// the previous response is being taken in the same cycle. If the receiver
// stalls, the response holds and the request side stalls behind it.
// Reset clears pointers, occupancy and the response valid flag and restores
// limit 1000 and threshold 40; the entry RAM needs no clearing pass since
// an entry is only read while it is held.
`include "threshold_marking_fifo_assert.svh"

module threshold_marking_fifo #(
	parameter int QUEUE_DEPTH     = tmf_pkg::TMF_QUEUE_DEPTH,
	parameter int DESCRIPTOR_BITS = tmf_pkg::TMF_DESC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                opcode,
	input  logic [tmf_pkg::DESC_PORT_W-1:0]     descriptor,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                accepted,
	output logic                                dropped,
	output logic                                marked_on_entry,
	output logic                                out_valid,
	output logic [tmf_pkg::DESC_PORT_W-1:0]     out_descriptor,
	output logic                                out_marked,
	output logic [tmf_pkg::CNT_W-1:0]           occupancy,
	output logic                                head_valid,
	output logic [tmf_pkg::DESC_PORT_W-1:0]     head_descriptor,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tmf_pkg::REG_W-1:0]           cfg_data
);

	import tmf_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int DB = DESCRIPTOR_BITS;

	// control state
	tmf_state_t      st_q, st_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [AW-1:0]   head_ptr_q, tail_ptr_q;
	logic [AW-1:0]   head_nxt, tail_nxt;
	logic [REG_W-1:0] limit_q, thresh_q;
	logic            rsp_valid_q;

	// cached head entry, mirrors the RAM word at head_ptr_q while non-empty
	logic [DB-1:0]   head_desc_q;
	logic            head_mark_q;

	// response register
	logic            accepted_q, dropped_q, marked_q;
	logic            deq_valid_q, deq_mark_q;
	logic [DESC_PORT_W-1:0] deq_desc_q, head_out_q;
	logic [CNT_W-1:0] occ_q;
	logic            head_valid_q;

	// decode
	logic            out_free, req_ok, is_enq, at_limit, not_empty, one_left, mark_c;
	logic [DB-1:0]   new_desc, head_after;
	logic            do_enq, do_drop, do_deq, do_fetch, fetch_done, item_now;
	logic [DB:0]     rd_data;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_ok    = req_valid && out_free;
	assign is_enq    = (opcode == OP_ENQ);
	assign not_empty = (count_q != '0);
	assign one_left  = (count_q == CNT_W'(1));
	// the configured limit and the physical depth both cap occupancy
	assign at_limit  = (count_q >= limit_q) || (32'(count_q) >= 32'(QUEUE_DEPTH));
	assign mark_c    = (count_q > thresh_q);
	assign new_desc  = DB'(descriptor);

	assign head_nxt = (head_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(head_ptr_q + 1'b1);
	assign tail_nxt = (tail_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(tail_ptr_q + 1'b1);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_ACCEPT: begin
				if (req_ok && !is_enq && not_empty && !one_left) begin
					st_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				st_d = ST_ACCEPT;
			end
			default: begin
				st_d = ST_ACCEPT;
			end
		endcase
	end

	// state outputs
	always_comb begin
		req_stall  = 1'b1;
		do_enq     = 1'b0;
		do_drop    = 1'b0;
		do_deq     = 1'b0;
		do_fetch   = 1'b0;
		fetch_done = 1'b0;
		unique case (st_q)
			ST_ACCEPT: begin
				req_stall = !out_free;
				if (req_ok) begin
					if (is_enq) begin
						do_enq  = !at_limit;
						do_drop = at_limit;
					end else if (not_empty) begin
						do_deq   = 1'b1;
						do_fetch = !one_left;
					end
				end
			end
			ST_FETCH: begin
				fetch_done = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// a response completes now unless it waits on the head fetch
	assign item_now = req_ok && (st_q == ST_ACCEPT) && !do_fetch;

	always_comb begin
		count_d = count_q;
		if (do_enq) begin
			count_d = CNT_W'(count_q + 1'b1);
		end else if (do_deq) begin
			count_d = CNT_W'(count_q - 1'b1);
		end
	end

	// an enqueue into an empty queue becomes the head at once
	assign head_after = (do_enq && !not_empty) ? new_desc : head_desc_q;

	// Entry RAM: writes at enqueue, reads the next head on a fetching dequeue.
	// The fetch state stalls requests, so a write never meets the read.
	tmf_ram #(
		.WIDTH (DB + 1),
		.DEPTH (QUEUE_DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (do_enq),
		.wr_addr (tail_ptr_q),
		.wr_data ({mark_c, new_desc}),
		.rd_en   (do_fetch),
		.rd_addr (head_nxt),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_ACCEPT;
			count_q     <= '0;
			head_ptr_q  <= '0;
			tail_ptr_q  <= '0;
			limit_q     <= LIMIT_RESET;
			thresh_q    <= THRESH_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
			if (do_enq) begin
				tail_ptr_q <= tail_nxt;
			end
			if (do_deq) begin
				head_ptr_q <= head_nxt;
			end
			// register writes; indexes beyond the list are ignored
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_IDX_LIMIT: begin
						limit_q <= cfg_data;
					end
					CFG_IDX_THRESH: begin
						thresh_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (item_now || fetch_done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload: head cache and response fields
	always_ff @(posedge clk) begin
		if (do_enq && !not_empty) begin
			head_desc_q <= new_desc;
			head_mark_q <= mark_c;
		end else if (fetch_done) begin
			head_desc_q <= rd_data[DB-1:0];
			head_mark_q <= rd_data[DB];
		end
		if (req_ok && (st_q == ST_ACCEPT)) begin
			accepted_q   <= do_enq;
			dropped_q    <= do_drop;
			marked_q     <= do_enq && mark_c;
			deq_valid_q  <= do_deq;
			deq_desc_q   <= do_deq ? DESC_PORT_W'(head_desc_q) : '0;
			deq_mark_q   <= do_deq && head_mark_q;
			occ_q        <= count_d;
			head_valid_q <= (count_d != '0);
			head_out_q   <= (count_d != '0) ? DESC_PORT_W'(head_after) : '0;
		end else if (fetch_done) begin
			head_valid_q <= 1'b1;
			head_out_q   <= DESC_PORT_W'(rd_data[DB-1:0]);
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign accepted        = accepted_q;
	assign dropped         = dropped_q;
	assign marked_on_entry = marked_q;
	assign out_valid       = deq_valid_q;
	assign out_descriptor  = deq_desc_q;
	assign out_marked      = deq_mark_q;
	assign occupancy       = occ_q;
	assign head_valid      = head_valid_q;
	assign head_descriptor = head_out_q;
	assign cfg_ready       = 1'b1;

	`TMF_ASSERT_IMPLY(a_fetch_empty_rsp, clk, arst_n, st_q == ST_FETCH, !rsp_valid_q,
		"head fetch started while a response was still held")
	`TMF_ASSERT_NEXT(a_fetch_delivers, clk, arst_n, st_q == ST_FETCH,
		rsp_valid_q && head_valid_q, "head fetch did not produce a response")
	`TMF_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1,
		32'(count_q) <= 32'(QUEUE_DEPTH), "occupancy exceeds queue depth")
	`TMF_ASSERT_IMPLY(a_head_flag, clk, arst_n, rsp_valid_q,
		(head_valid_q == (occ_q != '0)) && ($countones({accepted_q, dropped_q, deq_valid_q}) <= 1),
		"response flags inconsistent with occupancy")

endmodule

// ----- sv/tmf_ram.sv -----
module tmf_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
